@@ hw/rtl/strict_priority_event_queue_defines.svh @@
// ----------------------------------------------------------------------------
// Strict priority event queue assertion macros
// Shared concurrent assertion forms clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef STRICT_PRIORITY_EVENT_QUEUE_DEFINES_SVH
`define STRICT_PRIORITY_EVENT_QUEUE_DEFINES_SVH

// Same-cycle implication.
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// Strict priority event queue package
// Operation and status codes, field widths and default configuration.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int LEVELS_DEF        = 4;
    localparam int DEFAULT_LEVEL_DEF = 2;
    localparam int LEVEL_DEPTH_DEF   = 16;
    localparam int PAYLOAD_WIDTH_DEF = 32;

    localparam int OPCODE_W   = 2;
    localparam int STATUS_W   = 2;
    localparam int TAG_W      = 8;
    localparam int WORD_W     = 32;
    localparam int TOTAL_W    = 7;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH     = 2'd0,
        OP_POP      = 2'd1,
        OP_INIT     = 2'd2,
        OP_SHUTDOWN = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_STOPPED  = 2'd1,
        ST_NO_SPACE = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

endpackage

@@ hw/rtl/spq_store.sv @@
// ----------------------------------------------------------------------------
// Strict priority event queue entry store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spq_store #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 40
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/strict_priority_event_queue.sv @@
// ----------------------------------------------------------------------------
// Strict priority event queue
// A transfer's result is registered for the next cycle; one operation
// per cycle is taken while the result register drains, limited by the single
// entry store port pair. The input stalls only while a result waits stalled.
// Reset empties every level, starts the queue and needs no clearing pass.
// ----------------------------------------------------------------------------
`include "strict_priority_event_queue_defines.svh"

module strict_priority_event_queue #(
    parameter int LEVELS        = spq_pkg::LEVELS_DEF,
    parameter int DEFAULT_LEVEL = spq_pkg::DEFAULT_LEVEL_DEF,
    parameter int LEVEL_DEPTH   = spq_pkg::LEVEL_DEPTH_DEF,
    parameter int PAYLOAD_WIDTH = spq_pkg::PAYLOAD_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [spq_pkg::OPCODE_W-1:0]        opcode,
    input  logic signed [spq_pkg::TAG_W-1:0]    priority_in,
    input  logic [spq_pkg::WORD_W-1:0]          payload_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [spq_pkg::STATUS_W-1:0]        status,
    output logic signed [spq_pkg::TAG_W-1:0]    priority_out,
    output logic [spq_pkg::WORD_W-1:0]          payload_out,
    output logic [spq_pkg::TOTAL_W-1:0]         held_count
);

    localparam int LVL_W   = $clog2(LEVELS);
    localparam int SLOT_W  = $clog2(LEVEL_DEPTH);
    localparam int CNT_W   = $clog2(LEVEL_DEPTH + 1);
    localparam int DEPTH   = LEVELS * LEVEL_DEPTH;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int TOT_W   = $clog2(DEPTH + 1);
    localparam int STORE_W = (PAYLOAD_WIDTH < spq_pkg::WORD_W) ?
                             PAYLOAD_WIDTH : spq_pkg::WORD_W;
    localparam int DATA_W  = spq_pkg::TAG_W + STORE_W;
    localparam int DEF_LVL = (DEFAULT_LEVEL < LEVELS) ? DEFAULT_LEVEL : LEVELS - 1;

    logic [SLOT_W-1:0] head_reg  [LEVELS];
    logic [SLOT_W-1:0] head_next [LEVELS];
    logic [SLOT_W-1:0] tail_reg  [LEVELS];
    logic [SLOT_W-1:0] tail_next [LEVELS];
    logic [CNT_W-1:0]  count_reg [LEVELS];
    logic [CNT_W-1:0]  count_next[LEVELS];
    logic [TOT_W-1:0]  total_reg;
    logic [TOT_W-1:0]  total_next;
    logic              running_reg;
    logic              running_next;

    logic              out_valid_reg;
    spq_pkg::status_t  status_reg;
    spq_pkg::status_t  status_next;
    logic              hit_reg;
    logic              hit_next;

    logic              in_fire;
    spq_pkg::op_t      op;
    logic [LVL_W-1:0]  push_lvl;
    logic              push_full;
    logic [LVL_W-1:0]  pop_lvl;
    logic              pop_hit;
    logic [SLOT_W-1:0] tail_cur;
    logic [SLOT_W-1:0] head_cur;

    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] wr_data;
    logic [DATA_W-1:0] rd_data;

    logic [TOT_W+spq_pkg::TOTAL_W-1:0] total_wide;
    logic [STORE_W+spq_pkg::WORD_W-1:0] payload_wide;

    logic [TOT_W-1:0]  count_sum;
    logic              level_over;

    assign in_stall = out_valid_reg & out_stall;
    assign in_fire  = in_valid & ~in_stall;
    assign op       = spq_pkg::op_t'(opcode);

    always_comb
    begin
        if (!priority_in[spq_pkg::TAG_W-1] &&
            (spq_pkg::TAG_W'(priority_in) < spq_pkg::TAG_W'(LEVELS)))
        begin
            push_lvl = LVL_W'(priority_in[spq_pkg::TAG_W-2:0]);
        end
        else
        begin
            push_lvl = LVL_W'(DEF_LVL);
        end
    end

    assign tail_cur  = tail_reg[push_lvl];
    assign push_full = (count_reg[push_lvl] == CNT_W'(LEVEL_DEPTH));

    always_comb
    begin
        pop_lvl = '0;
        pop_hit = 1'b0;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (count_reg[i] != '0)
            begin
                pop_lvl = LVL_W'(i);
                pop_hit = 1'b1;
            end
        end
    end

    assign head_cur = head_reg[pop_lvl];

    assign wr_addr = ADDR_W'(push_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(tail_cur);
    assign rd_addr = ADDR_W'(pop_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(head_cur);
    assign wr_data = {priority_in, payload_in[STORE_W-1:0]};

    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        total_next   = total_reg;
        running_next = running_reg;
        status_next  = spq_pkg::ST_OK;
        hit_next     = 1'b0;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        unique case (op) inside
            spq_pkg::OP_PUSH:
            begin
                if (!running_reg)
                begin
                    status_next = spq_pkg::ST_STOPPED;
                end
                else if (push_full)
                begin
                    status_next = spq_pkg::ST_NO_SPACE;
                end
                else
                begin
                    wr_en = in_fire;
                    tail_next[push_lvl] = (tail_cur == SLOT_W'(LEVEL_DEPTH - 1)) ?
                                          '0 : tail_cur + SLOT_W'(1);
                    count_next[push_lvl] = count_reg[push_lvl] + CNT_W'(1);
                    total_next = total_reg + TOT_W'(1);
                end
            end
            spq_pkg::OP_POP:
            begin
                if (pop_hit)
                begin
                    rd_en    = in_fire;
                    hit_next = 1'b1;
                    head_next[pop_lvl] = (head_cur == SLOT_W'(LEVEL_DEPTH - 1)) ?
                                         '0 : head_cur + SLOT_W'(1);
                    count_next[pop_lvl] = count_reg[pop_lvl] - CNT_W'(1);
                    total_next = total_reg - TOT_W'(1);
                end
                else
                begin
                    status_next = spq_pkg::ST_EMPTY;
                end
            end
            spq_pkg::OP_INIT, spq_pkg::OP_SHUTDOWN:
            begin
                for (int i = 0; i < LEVELS; i++)
                begin
                    head_next[i]  = '0;
                    tail_next[i]  = '0;
                    count_next[i] = '0;
                end
                total_next   = '0;
                running_next = (op == spq_pkg::OP_INIT);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            total_reg     <= '0;
            running_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
            status_reg    <= spq_pkg::ST_OK;
            hit_reg       <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                head_reg    <= head_next;
                tail_reg    <= tail_next;
                count_reg   <= count_next;
                total_reg   <= total_next;
                running_reg <= running_next;
                status_reg  <= status_next;
                hit_reg     <= hit_next;
            end
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    spq_store #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign total_wide   = {{spq_pkg::TOTAL_W{1'b0}}, total_reg};
    assign payload_wide = {{spq_pkg::WORD_W{1'b0}}, rd_data[STORE_W-1:0]};

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign held_count   = total_wide[spq_pkg::TOTAL_W-1:0];
    assign priority_out = hit_reg ? rd_data[DATA_W-1:STORE_W] : '0;
    assign payload_out  = hit_reg ? payload_wide[spq_pkg::WORD_W-1:0] : '0;

    always_comb
    begin
        count_sum  = '0;
        level_over = 1'b0;
        for (int i = 0; i < LEVELS; i++)
        begin
            count_sum  = count_sum + TOT_W'(count_reg[i]);
            level_over = level_over | (count_reg[i] > CNT_W'(LEVEL_DEPTH));
        end
    end

    `SPQ_ASSERT_NOW(a_total_matches_levels, 1'b1, count_sum == total_reg,
        "Held total differs from the sum of the level counts.")
    `SPQ_ASSERT_NOW(a_level_bounded, 1'b1, !level_over,
        "A level count exceeds the level depth.")
    `SPQ_ASSERT_NOW(a_stopped_is_empty, !running_reg, total_reg == '0,
        "The queue holds entries while stopped.")
    `SPQ_ASSERT_NEXT(a_pop_removes_one,
        in_fire && (op == spq_pkg::OP_POP) && (total_reg != '0),
        total_reg == $past(total_reg) - TOT_W'(1),
        "A pop from a non-empty queue did not remove exactly one entry.")

endmodule

@@ tb/strict_priority_event_queue_checker.sv @@
// ----------------------------------------------------------------------------
// Strict priority event queue checker
// Watches the operation and result channels and predicts every result from
// its own copy of the per-level FIFOs. It compares each result transfer field
// by field with the oldest prediction and counts the failures.
// ----------------------------------------------------------------------------
module strict_priority_event_queue_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [spq_pkg::OPCODE_W-1:0]      opcode,
    input  logic signed [spq_pkg::TAG_W-1:0]  priority_in,
    input  logic [spq_pkg::WORD_W-1:0]        payload_in,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [spq_pkg::STATUS_W-1:0]      status,
    input  logic signed [spq_pkg::TAG_W-1:0]  priority_out,
    input  logic [spq_pkg::WORD_W-1:0]        payload_out,
    input  logic [spq_pkg::TOTAL_W-1:0]       held_count,
    output int unsigned                       fail_count,
    output int unsigned                       outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FALLBACK_LEVEL =
        (spq_pkg::DEFAULT_LEVEL_DEF < spq_pkg::LEVELS_DEF) ?
        spq_pkg::DEFAULT_LEVEL_DEF : spq_pkg::LEVELS_DEF - 1;
    localparam logic [spq_pkg::WORD_W-1:0] WORD_KEEP =
        {spq_pkg::WORD_W{1'b1}} >> (spq_pkg::WORD_W - spq_pkg::PAYLOAD_WIDTH_DEF);

    typedef struct {
        spq_pkg::status_t                 code;
        logic signed [spq_pkg::TAG_W-1:0] tag;
        logic [spq_pkg::WORD_W-1:0]       word;
        logic [spq_pkg::TOTAL_W-1:0]      held;
    } queue_result_t;

    logic [spq_pkg::WORD_W-1:0]
        slot_word [spq_pkg::LEVELS_DEF][spq_pkg::LEVEL_DEPTH_DEF];
    logic signed [spq_pkg::TAG_W-1:0]
        slot_tag  [spq_pkg::LEVELS_DEF][spq_pkg::LEVEL_DEPTH_DEF];
    int unsigned             lvl_head  [spq_pkg::LEVELS_DEF];
    int unsigned             lvl_tail  [spq_pkg::LEVELS_DEF];
    int unsigned             lvl_fill  [spq_pkg::LEVELS_DEF];
    int unsigned             held_events;
    bit                      running;
    queue_result_t           expected_results[$];

    function automatic void clear_levels();
        for (int i = 0; i < spq_pkg::LEVELS_DEF; i++)
        begin
            lvl_head[i] = 0;
            lvl_tail[i] = 0;
            lvl_fill[i] = 0;
        end
        held_events = 0;
    endfunction

    function automatic queue_result_t queue_step(spq_pkg::op_t op,
                                                 logic signed [spq_pkg::TAG_W-1:0] tag,
                                                 logic [spq_pkg::WORD_W-1:0] word);
        queue_result_t r;
        int            lvl;
        int unsigned   slot;
        r.code = spq_pkg::ST_OK;
        r.tag  = '0;
        r.word = '0;
        case (op)
            spq_pkg::OP_PUSH:
            begin
                if (!running)
                begin
                    r.code = spq_pkg::ST_STOPPED;
                end
                else
                begin
                    lvl = (tag >= 0 && tag < spq_pkg::LEVELS_DEF) ?
                          int'(tag) : FALLBACK_LEVEL;
                    if (lvl_fill[lvl] >= spq_pkg::LEVEL_DEPTH_DEF)
                    begin
                        r.code = spq_pkg::ST_NO_SPACE;
                    end
                    else
                    begin
                        slot = lvl_tail[lvl];
                        slot_word[lvl][slot] = word & WORD_KEEP;
                        slot_tag[lvl][slot]  = tag;
                        lvl_tail[lvl] = (slot + 1) % spq_pkg::LEVEL_DEPTH_DEF;
                        lvl_fill[lvl]++;
                        held_events++;
                    end
                end
            end
            spq_pkg::OP_POP:
            begin
                r.code = spq_pkg::ST_EMPTY;
                for (int i = 0; i < spq_pkg::LEVELS_DEF; i++)
                begin
                    if (r.code == spq_pkg::ST_EMPTY && lvl_fill[i] != 0)
                    begin
                        slot = lvl_head[i];
                        r.tag  = slot_tag[i][slot];
                        r.word = slot_word[i][slot];
                        lvl_head[i] = (slot + 1) % spq_pkg::LEVEL_DEPTH_DEF;
                        lvl_fill[i]--;
                        held_events--;
                        r.code = spq_pkg::ST_OK;
                    end
                end
            end
            default:
            begin
                clear_levels();
                running = (op == spq_pkg::OP_INIT);
            end
        endcase
        r.held = spq_pkg::TOTAL_W'(held_events);
        return r;
    endfunction

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        queue_result_t want;
        if (!rst_n)
        begin
            clear_levels();
            running = 1'b1;
            expected_results.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("Result transfer with no operation waiting for it.");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.code)
                    begin
                        $error("status: expected %0d, actual %0d", want.code, status);
                        fail_count++;
                    end
                    if (priority_out !== want.tag)
                    begin
                        $error("priority_out: expected %0d, actual %0d",
                               want.tag, priority_out);
                        fail_count++;
                    end
                    if (payload_out !== want.word)
                    begin
                        $error("payload_out: expected %h, actual %h",
                               want.word, payload_out);
                        fail_count++;
                    end
                    if (held_count !== want.held)
                    begin
                        $error("held_count: expected %0d, actual %0d",
                               want.held, held_count);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(
                    queue_step(spq_pkg::op_t'(opcode), priority_in, payload_in));
            end
        end
        outstanding = expected_results.size();
    end

endmodule

@@ tb/strict_priority_event_queue_tb.sv @@
// ----------------------------------------------------------------------------
// Strict priority event queue testbench
// Drives directed corner operations and then random bursts of pushes, pops,
// init and shutdown with random idling on both channels and one long result
// hold-off. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module strict_priority_event_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STIM_ITEMS  = 775;
    localparam int QUIET_TAIL  = 100;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 120;
    localparam int DRAIN_LIMIT = 1000;

    logic                              clk;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_stall;
    logic [spq_pkg::OPCODE_W-1:0]      opcode;
    logic signed [spq_pkg::TAG_W-1:0]  priority_in;
    logic [spq_pkg::WORD_W-1:0]        payload_in;
    logic                              out_valid;
    logic                              out_stall;
    logic [spq_pkg::STATUS_W-1:0]      status;
    logic signed [spq_pkg::TAG_W-1:0]  priority_out;
    logic [spq_pkg::WORD_W-1:0]        payload_out;
    logic [spq_pkg::TOTAL_W-1:0]       held_count;
    int unsigned                       fail_count;
    int unsigned                       outstanding;
    int unsigned                       items_sent;
    bit                                quiet;
    bit                                hold_done;

    strict_priority_event_queue u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .priority_in  (priority_in),
        .payload_in   (payload_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .priority_out (priority_out),
        .payload_out  (payload_out),
        .held_count   (held_count)
    );

    strict_priority_event_queue_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .priority_in  (priority_in),
        .payload_in   (payload_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .priority_out (priority_out),
        .payload_out  (payload_out),
        .held_count   (held_count),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial
    begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic signed [spq_pkg::TAG_W-1:0] pick_tag(int unsigned in_range_pct);
        if ($urandom_range(0, 99) < in_range_pct)
        begin
            return spq_pkg::TAG_W'($urandom_range(0, spq_pkg::LEVELS_DEF - 1));
        end
        return spq_pkg::TAG_W'($urandom);
    endfunction

    task automatic transfer_op(spq_pkg::op_t op, logic signed [spq_pkg::TAG_W-1:0] tag,
                               logic [spq_pkg::WORD_W-1:0] word);
        bit taken;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        priority_in <= tag;
        payload_in  <= word;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        items_sent++;
        if (items_sent >= STIM_ITEMS - QUIET_TAIL)
        begin
            quiet = 1'b1;
        end
    endtask

    task automatic random_op(int unsigned in_range_pct);
        transfer_op($urandom_range(0, 1) ? spq_pkg::OP_PUSH : spq_pkg::OP_POP,
                    pick_tag(in_range_pct), $urandom);
    endtask

    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!hold_done && items_sent >= HOLD_AT)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_done = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        logic signed [spq_pkg::TAG_W-1:0] corner_tags  [8];
        logic [spq_pkg::WORD_W-1:0]       corner_words [8];
        logic signed [spq_pkg::TAG_W-1:0] burst_tag;
        int unsigned                      pick;
        int unsigned                      waited;

        corner_tags  = '{8'sd0, 8'sd1, 8'sd2, 8'sd3, 8'sd4, 8'sd127, 8'sh80, 8'shFF};
        corner_words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                         32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
        items_sent = 0;
        quiet      = 1'b0;
        hold_done  = 1'b0;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        opcode      <= spq_pkg::OP_PUSH;
        priority_in <= '0;
        payload_in  <= '0;
        out_stall   <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        transfer_op(spq_pkg::OP_POP, 8'sd0, '0);
        for (int i = 0; i < 8; i++)
        begin
            transfer_op(spq_pkg::OP_PUSH, corner_tags[i], corner_words[i]);
        end
        repeat (9) transfer_op(spq_pkg::OP_POP, -8'sd1, 32'hFFFF_FFFF);
        transfer_op(spq_pkg::OP_PUSH, 8'sd3, 32'h1234_5678);
        transfer_op(spq_pkg::OP_SHUTDOWN, 8'sd0, '0);
        transfer_op(spq_pkg::OP_PUSH, 8'sd0, 32'hDEAD_BEEF);
        transfer_op(spq_pkg::OP_POP, 8'sd0, '0);
        transfer_op(spq_pkg::OP_INIT, 8'sd0, '0);

        while (items_sent < STIM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                burst_tag = pick_tag(75);
                repeat ($urandom_range(8, 20))
                    transfer_op(spq_pkg::OP_PUSH, burst_tag, $urandom);
            end
            else if (pick < 65)
            begin
                repeat ($urandom_range(4, 24))
                    transfer_op(spq_pkg::OP_POP, pick_tag(50), $urandom);
            end
            else if (pick < 92)
            begin
                repeat ($urandom_range(4, 12)) random_op(70);
            end
            else if (pick < 96)
            begin
                transfer_op(spq_pkg::OP_INIT, pick_tag(50), $urandom);
            end
            else
            begin
                transfer_op(spq_pkg::OP_SHUTDOWN, pick_tag(50), $urandom);
                repeat ($urandom_range(1, 4)) random_op(70);
                transfer_op(spq_pkg::OP_INIT, pick_tag(50), $urandom);
            end
        end

        in_valid <= 1'b0;
        waited = 0;
        do
        begin
            @(negedge clk);
            waited++;
        end
        while (outstanding != 0 && waited < DRAIN_LIMIT);
        repeat (4) @(posedge clk);
        @(negedge clk);
        if (outstanding != 0)
        begin
            $error("%0d expected results never arrived.", outstanding);
        end
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
